/* rtl/dfaet_pkg.sv */
// Shared types and constants for the edge-table automaton acceptor.
`default_nettype none

package dfaet_pkg;

  localparam int SYM_W   = 6;
  localparam int STATE_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = STATE_W;

  // request command codes
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_SYM = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL = 2'd1;

  typedef struct packed {
    logic               cmd;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic               last;
  } in_t;

  typedef struct packed {
    logic ok;
    logic accepted;
    logic end_of_string;
  } out_t;

  typedef struct packed {
    logic accept;   // request taken into the input register
    logic advance;  // input register moves on to the result register
  } pipe_ctl_t;

  typedef struct packed {
    logic [STATE_W-1:0] source;
    logic [STATE_W-1:0] target;
  } edge_t;

endpackage

`default_nettype wire

/* rtl/dfaet_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dfaet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/dfaet_core.sv */
// Input register, edge table and walk state; works out one result per request.
`default_nettype none

module dfaet_core #(
  parameter int NUM_SYMBOLS = 64,
  parameter int NUM_STATES  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire dfaet_pkg::pipe_ctl_t                ctl,
  input  wire dfaet_pkg::in_t                      in_data,
  input  wire logic                                cfg_wr,
  input  wire logic [dfaet_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dfaet_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                     busy,
  output dfaet_pkg::out_t                          result
);

  import dfaet_pkg::*;

  localparam int AW = $clog2(NUM_SYMBOLS);

  // input register
  logic           s1_valid;
  in_t            s1_data;

  logic [NUM_SYMBOLS-1:0] edge_valid;
  logic [STATE_W-1:0]     init_state;
  logic [STATE_W-1:0]     goal_state;
  logic [STATE_W-1:0]     current_state;
  logic                   in_string;
  logic                   path_broken;

  // bypass for an edge written in the cycle its symbol is read
  logic  fwd_hit;
  edge_t fwd_edge;

  logic [AW-1:0] rd_idx;
  logic [AW-1:0] s1_idx;
  edge_t         ram_edge;
  edge_t         s1_edge;
  logic          sym_ok;
  logic          add_ok;
  logic          wr_en;
  edge_t         wr_edge;

  logic               start;
  logic [STATE_W-1:0] cur;
  logic               broken;
  logic               step_ok;
  logic [STATE_W-1:0] current_state_next;
  logic               path_broken_next;

  assign rd_idx = AW'(in_data.symbol);
  assign s1_idx = AW'(s1_data.symbol);
  assign sym_ok = 32'(s1_data.symbol) < NUM_SYMBOLS;
  assign add_ok = sym_ok && !edge_valid[s1_idx]
                  && (32'(s1_data.from_state) < NUM_STATES)
                  && (32'(s1_data.to_state) < NUM_STATES);
  assign wr_en   = ctl.advance && (s1_data.cmd == CMD_ADD) && add_ok;
  assign wr_edge = '{source: s1_data.from_state, target: s1_data.to_state};
  assign s1_edge = fwd_hit ? fwd_edge : ram_edge;

  dfaet_ram #(
    .WIDTH ($bits(edge_t)),
    .DEPTH (NUM_SYMBOLS)
  ) u_edge_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_idx),
    .wr_data (wr_edge),
    .rd_en   (ctl.accept),
    .rd_addr (rd_idx),
    .rd_data (ram_edge)
  );

  // walk step; a new string restarts from the init register
  always_comb begin
    start   = !in_string;
    cur     = start ? init_state : current_state;
    broken  = start ? 1'b0 : path_broken;
    step_ok = sym_ok && edge_valid[s1_idx] && (s1_edge.source == cur);
    current_state_next = cur;
    path_broken_next   = broken;
    if (!broken) begin
      if (step_ok) begin
        current_state_next = s1_edge.target;
      end else begin
        path_broken_next = 1'b1;
      end
    end
  end

  always_comb begin
    if (s1_data.cmd == CMD_ADD) begin
      result = '{ok: add_ok, accepted: 1'b0, end_of_string: 1'b0};
    end else begin
      result.ok            = !path_broken_next;
      result.accepted      = s1_data.last && !path_broken_next
                             && (current_state_next == goal_state);
      result.end_of_string = s1_data.last;
    end
  end

  assign busy = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      edge_valid    <= '0;
      init_state    <= '0;
      goal_state    <= '0;
      current_state <= '0;
      in_string     <= 1'b0;
      path_broken   <= 1'b0;
      fwd_hit       <= 1'b0;
    end else begin
      if (ctl.accept) begin
        s1_valid <= 1'b1;
      end else if (ctl.advance) begin
        s1_valid <= 1'b0;
      end
      if (ctl.accept) begin
        fwd_hit <= wr_en && (s1_idx == rd_idx);
      end
      if (wr_en) begin
        edge_valid[s1_idx] <= 1'b1;
      end
      if (ctl.advance && (s1_data.cmd == CMD_SYM)) begin
        current_state <= current_state_next;
        path_broken   <= path_broken_next;
        in_string     <= !s1_data.last;
      end
      if (cfg_wr) begin
        case (cfg_index)
          REG_INIT: init_state <= cfg_data;
          REG_GOAL: goal_state <= cfg_data;
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      s1_data <= in_data;
      if (wr_en) begin
        fwd_edge <= wr_edge;
      end
    end
  end

  a_advance_needs_item: assert property (@(posedge clk) disable iff (rst)
    ctl.advance |-> s1_valid)
    else $error("result taken with no item in the input register");

  a_add_sets_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> edge_valid[$past(s1_idx)])
    else $error("added edge not marked valid");

  a_last_ends_string: assert property (@(posedge clk) disable iff (rst)
    (ctl.advance && s1_data.cmd == CMD_SYM && s1_data.last) |=> !in_string)
    else $error("string still open after its last symbol");

  a_accept_implies_ok: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && result.accepted) |-> (result.ok && result.end_of_string))
    else $error("acceptance reported on a broken or unfinished path");

endmodule

`default_nettype wire

/* rtl/dfa_edge_table_acceptor_unit.sv */
// Top level of the edge-table automaton acceptor: handshakes and result register.
// A request is taken into the input register, and its result is loaded into the result
// register when the input register advances, which waits while a result is not taken.
// Throughput: one request per cycle unless the output stalls; the edge table is one
// RAM read per request, with a bypass for an edge added by the request just ahead.
// Reset clears edge valid bits, walk state and both state registers at once;
// the table contents need no clearing pass.
`default_nettype none

module dfa_edge_table_acceptor_unit #(
  parameter int NUM_SYMBOLS = 64,
  parameter int NUM_STATES  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire dfaet_pkg::in_t                    in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output dfaet_pkg::out_t                        out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dfaet_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dfaet_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import dfaet_pkg::*;

  pipe_ctl_t ctl;
  logic      busy;
  out_t      result;

  assign ctl.advance = busy && (!out_valid || out_ready);
  assign in_ready    = !busy || ctl.advance;
  assign ctl.accept  = in_valid && in_ready;
  assign cfg_ready   = 1'b1;

  dfaet_core #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .NUM_STATES  (NUM_STATES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire
